// ===== design/msrq_pkg.sv =====
// ----------------------------------------------------------------------------
// msrq_pkg
// shared constants, status codes and state encodings of the message slot ring
// ----------------------------------------------------------------------------
package msrq_pkg;

  localparam int SLOTS_DEF      = 64;
  localparam int DATA_BYTES_DEF = 65536;
  localparam int KEY_BITS_DEF   = 64;

  localparam int KEY_PORT_W = 64;
  localparam int SIZE_W     = 20;
  localparam int OUT_W      = 16;
  localparam int CFG_IDX_W  = 2;

  localparam logic REQ_READ = 1'b1;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_TOO_LARGE = 3'd1,
    ST_NO_SLOT   = 3'd2,
    ST_NO_SPACE  = 3'd3,
    ST_NO_MSG    = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WEVAL,
    S_RPICK,
    S_RCHK
  } state_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_OVERFLOW = 2'd0,
    CFG_ANON     = 2'd1,
    CFG_OWN_KEY  = 2'd2,
    CFG_DEF_DEST = 2'd3
  } cfg_reg_t;

endpackage

// ===== design/msrq_ram.sv =====
// ----------------------------------------------------------------------------
// msrq_ram
// generic single write port ram with one registered read port
// ----------------------------------------------------------------------------
module msrq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== design/msrq_ctrl.sv =====
// ----------------------------------------------------------------------------
// msrq_ctrl
// request sequencer: slot search, eviction, payload allocation and read scan
// ----------------------------------------------------------------------------
module msrq_ctrl #(
  parameter int SLOTS      = msrq_pkg::SLOTS_DEF,
  parameter int DATA_BYTES = msrq_pkg::DATA_BYTES_DEF,
  parameter int KEY_BITS   = msrq_pkg::KEY_BITS_DEF,
  parameter int SW         = $clog2(SLOTS),
  parameter int EW         = 2 * KEY_BITS + 2 * $clog2(DATA_BYTES) + 1
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 in_req_type,
  input  logic [msrq_pkg::SIZE_W-1:0]          in_msg_size,
  input  logic [msrq_pkg::KEY_PORT_W-1:0]      in_dest_key,
  input  logic                                 in_use_default_dest,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [2:0]                           out_status,
  output logic [msrq_pkg::OUT_W-1:0]           out_data_offset,
  output logic [msrq_pkg::OUT_W-1:0]           out_size,
  output logic [msrq_pkg::KEY_PORT_W-1:0]      out_src_key,
  input  logic                                 cfg_we,
  input  logic [msrq_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [msrq_pkg::KEY_PORT_W-1:0]      cfg_wdata,
  output logic                                 ram_rd_en,
  output logic [SW-1:0]                        ram_rd_addr,
  input  logic [EW-1:0]                        ram_rd_data,
  output logic                                 ram_wr_en,
  output logic [SW-1:0]                        ram_wr_addr,
  output logic [EW-1:0]                        ram_wr_data
);

  import msrq_pkg::*;

  localparam int OW = $clog2(DATA_BYTES);
  localparam int LW = OW + 1;

  function automatic logic [SW-1:0] first_set(input logic [SLOTS-1:0] v);
    logic [SW-1:0] idx;
    idx = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (v[i]) idx = SW'(i);
    end
    return idx;
  endfunction

  function automatic logic [SW-1:0] next_slot(input logic [SW-1:0] i);
    return (i == SW'(SLOTS - 1)) ? '0 : i + SW'(1);
  endfunction

  function automatic logic [OUT_W-1:0] to_out(input logic [LW-1:0] v);
    logic [31:0] t;
    t = 32'(v);
    return t[OUT_W-1:0];
  endfunction

  state_t               state_r, state_nxt;
  logic [SLOTS-1:0]     used_r, used_nxt;
  logic [SLOTS-1:0]     rdy_r, rdy_nxt;
  logic [SLOTS-1:0]     mask_r, mask_nxt;
  logic [SW-1:0]        read_slot_r, read_slot_nxt;
  logic [SW-1:0]        write_slot_r, write_slot_nxt;
  logic [LW-1:0]        read_byte_r, read_byte_nxt;
  logic [LW-1:0]        write_byte_r, write_byte_nxt;
  logic [OW-1:0]        size_r, size_nxt;
  logic [KEY_BITS-1:0]  dest_r, dest_nxt;
  logic                 w_found_r, w_found_nxt;
  logic [SW-1:0]        w_idx_r, w_idx_nxt;
  logic [SW-1:0]        cand_r, cand_nxt;
  logic                 ovf_r, anon_r;
  logic [KEY_BITS-1:0]  own_key_r, def_dest_r;
  logic                 out_valid_r, out_valid_nxt;
  logic [2:0]           out_status_r, out_status_nxt;
  logic [OUT_W-1:0]     out_off_r, out_off_nxt;
  logic [OUT_W-1:0]     out_size_r, out_size_nxt;
  logic [KEY_BITS-1:0]  out_src_r, out_src_nxt;

  logic                 out_free;
  logic [31:0]          size32;
  logic                 too_large;
  logic [SLOTS-1:0]     w_hi, w_lo, r_hi, r_lo;
  logic                 w_any;
  logic [SW-1:0]        w_pick;
  logic                 r_any;
  logic [SW-1:0]        r_pick;

  logic [KEY_BITS-1:0]  e_src, e_dest;
  logic [LW-1:0]        e_off;
  logic [OW-1:0]        e_len;
  logic [SW-1:0]        w_idx;
  logic [LW-1:0]        rb, tail, sz, start;
  logic                 fits;

  assign out_free = !out_valid_r || !out_stall;
  assign in_stall = (state_r != S_IDLE) || !out_free;
  assign size32   = 32'(in_msg_size);
  assign too_large = size32 >= 32'(DATA_BYTES);

  assign e_src  = ram_rd_data[EW-1 -: KEY_BITS];
  assign e_dest = ram_rd_data[EW-KEY_BITS-1 -: KEY_BITS];
  assign e_off  = ram_rd_data[LW+OW-1:OW];
  assign e_len  = ram_rd_data[OW-1:0];

  // free slot and readable slot search over the flag vectors
  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      logic ge_w, lt_r1, ge_r, lt_w;
      ge_w  = SW'(i) >= write_slot_r;
      ge_r  = SW'(i) >= read_slot_r;
      lt_w  = SW'(i) < write_slot_r;
      lt_r1 = SW'(i) <= read_slot_r;
      if (read_slot_r <= write_slot_r) begin
        w_hi[i] = !used_r[i] && ge_w;
        w_lo[i] = !used_r[i] && !ge_w && !ge_r;
      end else begin
        w_hi[i] = !used_r[i] && ge_w && lt_r1;
        w_lo[i] = 1'b0;
      end
      if (write_slot_r <= read_slot_r) begin
        r_hi[i] = rdy_r[i] && mask_r[i] && ge_r;
        r_lo[i] = rdy_r[i] && mask_r[i] && !ge_r && lt_w;
      end else begin
        r_hi[i] = rdy_r[i] && mask_r[i] && ge_r && lt_w;
        r_lo[i] = 1'b0;
      end
    end
    w_any  = |w_hi || |w_lo;
    w_pick = |w_hi ? first_set(w_hi) : first_set(w_lo);
    r_any  = |r_hi || |r_lo;
    r_pick = |r_hi ? first_set(r_hi) : first_set(r_lo);
  end

  // payload allocation
  always_comb begin
    w_idx = w_found_r ? w_idx_r : read_slot_r;
    rb    = w_found_r ? read_byte_r : e_off + LW'(e_len);
    tail  = LW'(DATA_BYTES) - write_byte_r;
    sz    = LW'(size_r);
    start = write_byte_r;
    fits  = 1'b0;
    if (write_byte_r >= rb) begin
      if (tail >= sz) begin
        fits = 1'b1;
      end else begin
        start = '0;
        fits  = rb >= sz;
      end
    end else begin
      fits = (rb - write_byte_r) >= sz;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    used_nxt       = used_r;
    rdy_nxt        = rdy_r;
    mask_nxt       = mask_r;
    read_slot_nxt  = read_slot_r;
    write_slot_nxt = write_slot_r;
    read_byte_nxt  = read_byte_r;
    write_byte_nxt = write_byte_r;
    size_nxt       = size_r;
    dest_nxt       = dest_r;
    w_found_nxt    = w_found_r;
    w_idx_nxt      = w_idx_r;
    cand_nxt       = cand_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_status_nxt = out_status_r;
    out_off_nxt    = out_off_r;
    out_size_nxt   = out_size_r;
    out_src_nxt    = out_src_r;
    ram_rd_en      = 1'b0;
    ram_rd_addr    = read_slot_r;
    ram_wr_en      = 1'b0;
    ram_wr_addr    = w_idx;
    ram_wr_data    = {own_key_r, dest_r, LW'(0), OW'(0)};

    case (state_r)
      S_IDLE: begin
        if (in_valid && !in_stall) begin
          size_nxt    = size32[OW-1:0];
          dest_nxt    = in_use_default_dest ? def_dest_r : in_dest_key[KEY_BITS-1:0];
          w_found_nxt = w_any;
          w_idx_nxt   = w_pick;
          mask_nxt    = '1;
          if (in_req_type == REQ_READ) begin
            state_nxt = S_RPICK;
          end else if (too_large) begin
            out_valid_nxt  = 1'b1;
            out_status_nxt = ST_TOO_LARGE;
            out_off_nxt    = '0;
            out_size_nxt   = '0;
            out_src_nxt    = '0;
          end else begin
            ram_rd_en = 1'b1;
            state_nxt = S_WEVAL;
          end
        end
      end
      S_WEVAL: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_src_nxt   = '0;
          out_off_nxt   = '0;
          out_size_nxt  = '0;
          state_nxt     = S_IDLE;
          if (!w_found_r && !ovf_r) begin
            out_status_nxt = ST_NO_SLOT;
          end else begin
            if (!w_found_r) begin
              read_slot_nxt = next_slot(read_slot_r);
              read_byte_nxt = rb;
            end
            write_slot_nxt = next_slot(w_idx);
            ram_wr_en      = 1'b1;
            used_nxt[w_idx] = 1'b0;
            rdy_nxt[w_idx]  = 1'b0;
            if (fits) begin
              write_byte_nxt  = start + sz;
              ram_wr_data     = {own_key_r, dest_r, start, size_r};
              used_nxt[w_idx] = 1'b1;
              rdy_nxt[w_idx]  = size_r != '0;
              out_status_nxt  = ST_OK;
              out_off_nxt     = to_out(start);
              out_size_nxt    = to_out(sz);
            end else begin
              out_status_nxt = ST_NO_SPACE;
            end
          end
        end
      end
      S_RPICK: begin
        if (r_any) begin
          cand_nxt    = r_pick;
          ram_rd_en   = 1'b1;
          ram_rd_addr = r_pick;
          state_nxt   = S_RCHK;
        end else if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = ST_NO_MSG;
          out_off_nxt    = '0;
          out_size_nxt   = '0;
          out_src_nxt    = '0;
          state_nxt      = S_IDLE;
        end
      end
      S_RCHK: begin
        if (anon_r || e_dest == own_key_r) begin
          if (out_free) begin
            read_slot_nxt = next_slot(read_slot_r);
            if (e_off == read_byte_r) begin
              read_byte_nxt = read_byte_r + LW'(e_len);
            end
            used_nxt[cand_r] = 1'b0;
            rdy_nxt[cand_r]  = 1'b0;
            out_valid_nxt    = 1'b1;
            out_status_nxt   = ST_OK;
            out_off_nxt      = to_out(e_off);
            out_size_nxt     = to_out(LW'(e_len));
            out_src_nxt      = e_src;
            state_nxt        = S_IDLE;
          end
        end else begin
          mask_nxt[cand_r] = 1'b0;
          state_nxt        = S_RPICK;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      used_r       <= '0;
      rdy_r        <= '0;
      read_slot_r  <= '0;
      write_slot_r <= '0;
      read_byte_r  <= '0;
      write_byte_r <= '0;
      out_valid_r  <= 1'b0;
      ovf_r        <= 1'b0;
      anon_r       <= 1'b0;
      own_key_r    <= '0;
      def_dest_r   <= '0;
    end else begin
      state_r      <= state_nxt;
      used_r       <= used_nxt;
      rdy_r        <= rdy_nxt;
      read_slot_r  <= read_slot_nxt;
      write_slot_r <= write_slot_nxt;
      read_byte_r  <= read_byte_nxt;
      write_byte_r <= write_byte_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_we) begin
        case (cfg_reg_t'(cfg_index))
          CFG_OVERFLOW: ovf_r      <= cfg_wdata[0];
          CFG_ANON:     anon_r     <= cfg_wdata[0];
          CFG_OWN_KEY:  own_key_r  <= cfg_wdata[KEY_BITS-1:0];
          CFG_DEF_DEST: def_dest_r <= cfg_wdata[KEY_BITS-1:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    mask_r       <= mask_nxt;
    size_r       <= size_nxt;
    dest_r       <= dest_nxt;
    w_found_r    <= w_found_nxt;
    w_idx_r      <= w_idx_nxt;
    cand_r       <= cand_nxt;
    out_status_r <= out_status_nxt;
    out_off_r    <= out_off_nxt;
    out_size_r   <= out_size_nxt;
    out_src_r    <= out_src_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_data_offset = out_off_r;
  assign out_size        = out_size_r;
  assign out_src_key     = KEY_PORT_W'(out_src_r);

endmodule

// ===== design/message_slot_ring_queue_core.sv =====
// ----------------------------------------------------------------------------
// message_slot_ring_queue_core
// mailbox with a ring of message descriptor slots and a ring of payload bytes
// ----------------------------------------------------------------------------
// requests enter on the in_ channel (valid/stall) and each gives exactly one
// result on the out_ channel; registers are set through the cfg_ write port;
// the user writes them only while the block is idle, which is not enforced.
// a write: the free slot search over the used flags runs in the transfer
// cycle, together with the descriptor ram read (for a possible eviction);
// allocation and write-back finish in S_WEVAL when the result register is free.
// a too-large write is answered from the transfer cycle, with no ram read.
// a read checks candidate slots one at a time in S_RPICK and S_RCHK, moving
// past every candidate whose destination key does not match; each check is a
// ram read followed by a compare, so the single ram read port sets the rate.
// one request is in flight at a time; the next transfer is taken as soon as
// the block is idle and the result register is free or being emptied.
// reset clears the slot flags, indices and registers; the descriptor ram is
// not cleared.
// while out_stall is high and a result is pending, the result holds and no new request is finished.
// ----------------------------------------------------------------------------
module message_slot_ring_queue_core #(
  parameter int SLOTS      = msrq_pkg::SLOTS_DEF,
  parameter int DATA_BYTES = msrq_pkg::DATA_BYTES_DEF,
  parameter int KEY_BITS   = msrq_pkg::KEY_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_req_type,
  input  logic [msrq_pkg::SIZE_W-1:0]      in_msg_size,
  input  logic [msrq_pkg::KEY_PORT_W-1:0]  in_dest_key,
  input  logic                             in_use_default_dest,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [2:0]                       out_status,
  output logic [msrq_pkg::OUT_W-1:0]       out_data_offset,
  output logic [msrq_pkg::OUT_W-1:0]       out_size,
  output logic [msrq_pkg::KEY_PORT_W-1:0]  out_src_key,
  input  logic                             cfg_we,
  input  logic [msrq_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [msrq_pkg::KEY_PORT_W-1:0]  cfg_wdata
);

  import msrq_pkg::*;

  localparam int SW = $clog2(SLOTS);
  localparam int EW = 2 * KEY_BITS + 2 * $clog2(DATA_BYTES) + 1;

  logic          ram_rd_en;
  logic [SW-1:0] ram_rd_addr;
  logic [EW-1:0] ram_rd_data;
  logic          ram_wr_en;
  logic [SW-1:0] ram_wr_addr;
  logic [EW-1:0] ram_wr_data;

  msrq_ctrl #(
    .SLOTS      (SLOTS),
    .DATA_BYTES (DATA_BYTES),
    .KEY_BITS   (KEY_BITS),
    .SW         (SW),
    .EW         (EW)
  ) u_ctrl (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_req_type         (in_req_type),
    .in_msg_size         (in_msg_size),
    .in_dest_key         (in_dest_key),
    .in_use_default_dest (in_use_default_dest),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_status          (out_status),
    .out_data_offset     (out_data_offset),
    .out_size            (out_size),
    .out_src_key         (out_src_key),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .ram_rd_en           (ram_rd_en),
    .ram_rd_addr         (ram_rd_addr),
    .ram_rd_data         (ram_rd_data),
    .ram_wr_en           (ram_wr_en),
    .ram_wr_addr         (ram_wr_addr),
    .ram_wr_data         (ram_wr_data)
  );

  msrq_ram #(
    .WIDTH (EW),
    .DEPTH (SLOTS)
  ) u_desc_ram (
    .clk     (clk),
    .wr_en   (ram_wr_en),
    .wr_addr (ram_wr_addr),
    .wr_data (ram_wr_data),
    .rd_en   (ram_rd_en),
    .rd_addr (ram_rd_addr),
    .rd_data (ram_rd_data)
  );

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// message slot ring queue testbench
// drives write and read requests with random gaps on both channels, predicts
// each result from a model of the slot and payload rings, and compares every
// result transfer field by field across several register settings
// ----------------------------------------------------------------------------
import msrq_pkg::*;

class mailbox_scoreboard;
  localparam int NSLOT = 64;
  localparam int NBYTE = 65536;

  bit          overflow_en;
  bit          anon_rd;
  logic [63:0] own_key;
  logic [63:0] def_dest;

  bit          used[NSLOT];
  bit          written[NSLOT];
  logic [63:0] src[NSLOT];
  logic [63:0] dst[NSLOT];
  int unsigned offs[NSLOT];
  int unsigned lens[NSLOT];
  int unsigned rd_slot, wr_slot, rd_byte, wr_byte;

  status_t     exp_status[$];
  logic [15:0] exp_offset[$];
  logic [15:0] exp_size[$];
  logic [63:0] exp_src[$];
  int          mismatches;

  function new();
    for (int i = 0; i < NSLOT; i++) begin
      used[i] = 0;
      written[i] = 0;
    end
    rd_slot = 0; wr_slot = 0; rd_byte = 0; wr_byte = 0;
    overflow_en = 0; anon_rd = 0; own_key = '0; def_dest = '0;
    mismatches = 0;
  endfunction

  function void set_reg(cfg_reg_t idx, logic [63:0] val);
    case (idx)
      CFG_OVERFLOW: overflow_en = val[0];
      CFG_ANON:     anon_rd = val[0];
      CFG_OWN_KEY:  own_key = val;
      CFG_DEF_DEST: def_dest = val;
      default: ;
    endcase
  endfunction

  function int unsigned nxt(int unsigned i);
    return (i + 1 >= NSLOT) ? 0 : i + 1;
  endfunction

  function bit free_in(int unsigned lo, int unsigned hi, output int unsigned idx);
    idx = 0;
    for (int unsigned i = lo; i < hi && i < NSLOT; i++)
      if (!used[i]) begin
        idx = i;
        return 1;
      end
    return 0;
  endfunction

  function bit pick_free(output int unsigned idx);
    bit ok;
    if (rd_slot <= wr_slot) begin
      ok = free_in(wr_slot, NSLOT, idx);
      if (!ok) ok = free_in(0, rd_slot, idx);
    end else begin
      ok = free_in(wr_slot, rd_slot + 1, idx);
    end
    return ok;
  endfunction

  // an eviction of a slot that was never allocated must not be caused
  function bit unsafe_write(logic [19:0] size);
    int unsigned idx;
    if (size >= NBYTE) return 0;
    if (pick_free(idx)) return 0;
    return overflow_en && !written[rd_slot];
  endfunction

  function bit readable(int unsigned i);
    if (!used[i] || lens[i] == 0) return 0;
    if (!anon_rd && dst[i] != own_key) return 0;
    return 1;
  endfunction

  function bit readable_in(int unsigned lo, int unsigned hi, output int unsigned idx);
    idx = 0;
    for (int unsigned i = lo; i < hi && i < NSLOT; i++)
      if (readable(i)) begin
        idx = i;
        return 1;
      end
    return 0;
  endfunction

  function void note(logic rq, logic [19:0] size, logic [63:0] dkey, logic use_def);
    status_t     st;
    int unsigned idx, start, stop, off, len;
    logic [63:0] s;
    bit          ok, wrap;
    off = 0; len = 0; s = '0; st = ST_OK;
    if (rq == REQ_READ) begin
      if (wr_slot <= rd_slot) begin
        ok = readable_in(rd_slot, NSLOT, idx);
        if (!ok) ok = readable_in(0, wr_slot, idx);
      end else begin
        ok = readable_in(rd_slot, wr_slot, idx);
      end
      if (!ok) st = ST_NO_MSG;
      else begin
        rd_slot = nxt(rd_slot);
        if (offs[idx] == rd_byte) rd_byte += lens[idx];
        off = offs[idx]; len = lens[idx]; s = src[idx];
        used[idx] = 0;
      end
    end else if (size >= NBYTE) begin
      st = ST_TOO_LARGE;
    end else begin
      ok = pick_free(idx);
      if (!ok && !overflow_en) st = ST_NO_SLOT;
      else begin
        if (!ok) begin
          idx = rd_slot;
          rd_slot = nxt(idx);
          rd_byte = offs[idx] + lens[idx];
        end
        wr_slot = nxt(idx);
        used[idx] = 0;
        written[idx] = 1;
        src[idx] = own_key;
        dst[idx] = use_def ? def_dest : dkey;
        offs[idx] = 0;
        lens[idx] = 0;
        start = wr_byte;
        wrap = wr_byte >= rd_byte;
        stop = wrap ? NBYTE : rd_byte;
        if (wrap && (stop > start ? stop - start : 0) < size) begin
          start = 0;
          stop = rd_byte;
        end
        if ((stop > start ? stop - start : 0) < size) st = ST_NO_SPACE;
        else begin
          wr_byte = start + 32'(size);
          offs[idx] = start;
          lens[idx] = 32'(size);
          used[idx] = 1;
          off = start;
          len = 32'(size);
        end
      end
    end
    exp_status.push_back(st);
    exp_offset.push_back(off[15:0]);
    exp_size.push_back(len[15:0]);
    exp_src.push_back(s);
  endfunction

  function void check(logic [2:0] st, logic [15:0] off, logic [15:0] sz, logic [63:0] s);
    if (exp_status.size() == 0) begin
      mismatches++;
      if (mismatches <= 10) $display("result with nothing outstanding: status %0d", st);
      return;
    end
    if (st !== exp_status[0] || off !== exp_offset[0] || sz !== exp_size[0]
        || s !== exp_src[0]) begin
      mismatches++;
      if (mismatches <= 10)
        $display("exp st %0d off %0d size %0d src %h / got st %0d off %0d size %0d src %h",
                 exp_status[0], exp_offset[0], exp_size[0], exp_src[0], st, off, sz, s);
    end
    void'(exp_status.pop_front());
    void'(exp_offset.pop_front());
    void'(exp_size.pop_front());
    void'(exp_src.pop_front());
  endfunction

  function int pending();
    return exp_status.size();
  endfunction
endclass

module testbench;
  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_valid = 0;
  logic        in_stall;
  logic        in_req_type = 0;
  logic [19:0] in_msg_size = '0;
  logic [63:0] in_dest_key = '0;
  logic        in_use_default_dest = 0;
  logic        out_valid;
  logic        out_stall = 0;
  logic [2:0]  out_status;
  logic [15:0] out_data_offset;
  logic [15:0] out_size;
  logic [63:0] out_src_key;
  logic        cfg_we = 0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [63:0] cfg_wdata = '0;

  mailbox_scoreboard sb = new();
  bit  no_idle = 0;
  bit  long_req = 0;
  int  rx_hold = 0;
  int  long_hold = 0;
  int  quiet = 0;

  message_slot_ring_queue_core DUT (.*);

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  always @(posedge clk) begin
    if (out_valid && !out_stall)
      sb.check(out_status, out_data_offset, out_size, out_src_key);
    if (long_req) begin
      long_req = 0;
      long_hold = 400;
    end
    if (long_hold > 0) begin
      long_hold--;
      out_stall <= 1;
    end else if (out_valid && !out_stall) begin
      rx_hold = no_idle ? 0 : $urandom_range(0, 12);
      out_stall <= (rx_hold > 0);
    end else begin
      if (rx_hold > 0) rx_hold--;
      out_stall <= (rx_hold > 0);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet > 20000) begin
      $display("message_slot_ring_queue_core: mismatch");
      $finish;
    end
  end

  task automatic write_reg(cfg_reg_t idx, logic [63:0] val);
    @(posedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_wdata <= val;
    sb.set_reg(idx, val);
    @(posedge clk);
    cfg_we <= 0;
  endtask

  task automatic drain();
    in_valid <= 0;
    while (sb.pending() > 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic send(logic rq, logic [19:0] size, logic [63:0] dkey, logic use_def);
    int gap;
    if (rq != REQ_READ && sb.unsafe_write(size)) rq = REQ_READ;
    gap = no_idle ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    in_req_type <= rq;
    in_msg_size <= size;
    in_dest_key <= dkey;
    in_use_default_dest <= use_def;
    do @(posedge clk); while (!(in_valid && !in_stall));
    sb.note(rq, size, dkey, use_def);
  endtask

  task automatic random_item();
    logic [19:0] size;
    logic [63:0] dkey;
    logic        use_def;
    int          p;
    p = $urandom_range(0, 99);
    if (p < 70) size = 20'($urandom_range(0, 1500));
    else if (p < 85) size = 20'($urandom_range(0, 65535));
    else if (p < 90) size = 0;
    else if (p < 97) size = 20'($urandom_range(65536, 1048575));
    else size = 20'($urandom);
    p = $urandom_range(0, 99);
    use_def = 0;
    if (p < 55) dkey = sb.own_key;
    else if (p < 75) begin
      dkey = {$urandom, $urandom};
      use_def = 1;
    end else dkey = {$urandom, $urandom};
    send($urandom_range(0, 99) < 48 ? REQ_READ : ~REQ_READ, size, dkey, use_def);
  endtask

  initial begin
    logic [63:0] keys[5];
    keys[0] = '0;
    keys[1] = '1;
    keys[2] = {$urandom, $urandom};
    keys[3] = {$urandom, $urandom};
    keys[4] = 64'h5555_aaaa_0f0f_f0f0;
    repeat (4) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed
    write_reg(CFG_OWN_KEY, 64'h0123_4567_89ab_cdef);
    write_reg(CFG_DEF_DEST, 64'h0123_4567_89ab_cdef);
    write_reg(CFG_OVERFLOW, 64'd0);
    write_reg(CFG_ANON, 64'd0);
    send(REQ_READ, 20'd0, '0, 0);
    send(~REQ_READ, 20'd0, 64'h0123_4567_89ab_cdef, 0);
    send(REQ_READ, 20'd0, '0, 0);
    send(~REQ_READ, 20'd65536, '1, 1);
    send(~REQ_READ, 20'hFFFFF, '1, 0);
    send(~REQ_READ, 20'd100, '0, 1);
    send(~REQ_READ, 20'd200, '1, 0);
    send(REQ_READ, 20'hFFFFF, '1, 1);
    send(REQ_READ, 20'd0, '0, 0);
    send(~REQ_READ, 20'd65535, 64'h0123_4567_89ab_cdef, 0);
    send(~REQ_READ, 20'd1, 64'h0123_4567_89ab_cdef, 0);
    send(REQ_READ, 20'd0, '0, 0);
    drain();
    write_reg(CFG_ANON, 64'd1);
    send(REQ_READ, 20'd0, '0, 0);
    send(REQ_READ, 20'd0, '0, 0);
    send(REQ_READ, 20'd0, '0, 0);
    drain();

    for (int ph = 0; ph < 6; ph++) begin
      write_reg(CFG_OVERFLOW, 64'(ph % 2));
      write_reg(CFG_ANON, 64'((ph / 2) % 2));
      write_reg(CFG_OWN_KEY, keys[ph % 5]);
      write_reg(CFG_DEF_DEST, ph == 1 ? '1 : (ph == 3 ? '0 : keys[(ph + 2) % 5]));
      no_idle = (ph == 4);
      if (ph == 2) long_req = 1;
      for (int n = 0; n < 205; n++) begin
        if (ph == 3 && n == 100) drain();
        if (ph % 2 == 0 && n < 80 && $urandom_range(0, 1))
          send(~REQ_READ, 20'($urandom_range(0, 900)), sb.own_key, 0);
        else random_item();
      end
      in_valid <= 0;
      drain();
    end
    no_idle = 0;

    drain();
    repeat (20) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("message_slot_ring_queue_core: match");
    else
      $display("message_slot_ring_queue_core: mismatch");
    $finish;
  end
endmodule
